[hdl/nntc_pkg.sv]
// package for the number and name token checker
// holds scanner state types, character codes and character class functions
// no dependencies
`default_nettype none

package nntc_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned MaskW = 64;
	localparam int unsigned OutW  = 8;

	localparam logic [CharW-1:0] ChNul   = 8'd0;
	localparam logic [CharW-1:0] ChPlus  = 8'h2b;
	localparam logic [CharW-1:0] ChMinus = 8'h2d;
	localparam logic [CharW-1:0] ChDot   = 8'h2e;
	localparam logic [CharW-1:0] ChLowE  = 8'h65;
	localparam logic [CharW-1:0] ChUpE   = 8'h45;
	localparam logic [CharW-1:0] ChUnder = 8'h5f;
	localparam logic [CharW-1:0] ChGraphLo = 8'd33;
	localparam logic [CharW-1:0] ChGraphHi = 8'd126;

	// register indexes of the configuration port
	localparam logic RegMaskLow  = 1'b0;
	localparam logic RegMaskHigh = 1'b1;

	typedef enum logic [4:0] {
		IP_WS   = 5'b00001,
		IP_SIGN = 5'b00010,
		IP_DIG  = 5'b00100,
		IP_END  = 5'b01000,
		IP_FAIL = 5'b10000
	} int_phase_t;

	typedef enum logic [7:0] {
		FP_WS    = 8'b00000001,
		FP_MANT  = 8'b00000010,
		FP_FRAC  = 8'b00000100,
		FP_EWS   = 8'b00001000,
		FP_ESIGN = 8'b00010000,
		FP_EDIG  = 8'b00100000,
		FP_END   = 8'b01000000,
		FP_FAIL  = 8'b10000000
	} float_phase_t;

	typedef enum logic [2:0] {
		NP_UNDER = 3'b001,
		NP_BODY  = 3'b010,
		NP_FAIL  = 3'b100
	} name_phase_t;

	typedef enum logic [2:0] {
		V_UNDEC = 3'b001,
		V_YES   = 3'b010,
		V_NO    = 3'b100
	} verdict_t;

	function automatic logic is_ws(input logic [CharW-1:0] c);
		return c == 8'd9 || c == 8'd10 || c == 8'd12 || c == 8'd13 || c == 8'd32;
	endfunction

	function automatic logic is_digit(input logic [CharW-1:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic logic is_letter(input logic [CharW-1:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
	endfunction

	function automatic logic is_sign(input logic [CharW-1:0] c);
		return c == ChPlus || c == ChMinus;
	endfunction

endpackage

`default_nettype wire

[hdl/number_and_name_token_checker.sv]
// number and name token checker, top level
// uses nntc_pkg for scanner state types and character classes
// byte stream in, one five-verdict result per NUL-terminated string out
`default_nettype none

// Feed a NUL-terminated string one byte per transaction on the s_ side; a new
// byte may be sent every cycle while input is not held back, since the
// integer, float and name scanners each move one step per byte in the logic
// between the input register and the result register. Only the NUL byte gives
// a result: one transaction on the m_ side with five verdict bits, after which
// all scanners start over for the next string. Input is held back only while
// a NUL waits in the input register and the previous result has not been
// taken. The delimiter masks (index 0: codes 0..63, index 1: codes 64..127)
// are written through cfg_we/cfg_index/cfg_data while the stream is idle;
// NUL always counts as a delimiter.
module number_and_name_token_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // ch
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // int_ok, int_delimited_ok, float_ok,
	                                    // float_delimited_ok, name_ok, zero pad
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [nntc_pkg::MaskW-1:0] mask_lo_q, mask_hi_q;

	logic                       valid_s1;
	logic [nntc_pkg::CharW-1:0] ch_s1;

	nntc_pkg::int_phase_t   int_q, int_n;
	nntc_pkg::float_phase_t flt_q, flt_n, flt_eff;
	nntc_pkg::name_phase_t  name_q, name_n;
	nntc_pkg::verdict_t     iv_q, iv_n, fv_q, fv_n;
	logic                   mseen_q, mseen_n;

	logic       is_nul, consume, flt_done;
	nntc_pkg::verdict_t dv;
	logic [4:0] verdicts;

	assign is_nul   = ch_s1 == nntc_pkg::ChNul;
	assign consume  = valid_s1 && (!is_nul || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || consume;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo_q <= '0;
			mask_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nntc_pkg::RegMaskLow:  mask_lo_q <= cfg_data;
				nntc_pkg::RegMaskHigh: mask_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// delimiter verdict of the byte in the input register
	always_comb begin
		if (is_nul) begin
			dv = nntc_pkg::V_YES;
		end else if (ch_s1[7]) begin
			dv = nntc_pkg::V_NO;
		end else if (ch_s1[6]) begin
			dv = mask_hi_q[ch_s1[5:0]] ? nntc_pkg::V_YES : nntc_pkg::V_NO;
		end else begin
			dv = mask_lo_q[ch_s1[5:0]] ? nntc_pkg::V_YES : nntc_pkg::V_NO;
		end
	end

	// integer scanner
	always_comb begin
		int_n = int_q;
		iv_n  = iv_q;
		unique case (int_q)
			nntc_pkg::IP_WS: begin
				if (nntc_pkg::is_ws(ch_s1)) begin
					int_n = int_q;
				end else if (nntc_pkg::is_sign(ch_s1)) begin
					int_n = nntc_pkg::IP_SIGN;
				end else if (nntc_pkg::is_digit(ch_s1)) begin
					int_n = nntc_pkg::IP_DIG;
				end else begin
					int_n = nntc_pkg::IP_FAIL;
					iv_n  = nntc_pkg::V_NO;
				end
			end
			nntc_pkg::IP_SIGN: begin
				if (nntc_pkg::is_digit(ch_s1)) begin
					int_n = nntc_pkg::IP_DIG;
				end else begin
					int_n = nntc_pkg::IP_FAIL;
					iv_n  = nntc_pkg::V_NO;
				end
			end
			nntc_pkg::IP_DIG: begin
				if (!nntc_pkg::is_digit(ch_s1)) begin
					int_n = nntc_pkg::IP_END;
					iv_n  = dv;
				end
			end
			default: ;
		endcase
	end

	// float scanner; leading whitespace and sign fold into the mantissa phase
	always_comb begin
		flt_n    = flt_q;
		fv_n     = fv_q;
		mseen_n  = mseen_q;
		flt_eff  = flt_q;
		flt_done = 1'b0;
		if (flt_q == nntc_pkg::FP_WS) begin
			if (nntc_pkg::is_ws(ch_s1)) begin
				flt_done = 1'b1;
			end else begin
				flt_eff = nntc_pkg::FP_MANT;
				flt_n   = nntc_pkg::FP_MANT;
				flt_done = nntc_pkg::is_sign(ch_s1);
			end
		end
		if (!flt_done) begin
			unique case (flt_eff)
				nntc_pkg::FP_MANT, nntc_pkg::FP_FRAC: begin
					priority if (nntc_pkg::is_digit(ch_s1)) begin
						mseen_n = 1'b1;
					end else if (flt_eff == nntc_pkg::FP_MANT && ch_s1 == nntc_pkg::ChDot) begin
						flt_n = nntc_pkg::FP_FRAC;
					end else if (!mseen_q) begin
						flt_n = nntc_pkg::FP_FAIL;
						fv_n  = nntc_pkg::V_NO;
					end else if (ch_s1 == nntc_pkg::ChLowE || ch_s1 == nntc_pkg::ChUpE) begin
						flt_n = nntc_pkg::FP_EWS;
					end else begin
						flt_n = nntc_pkg::FP_END;
						fv_n  = dv;
					end
				end
				nntc_pkg::FP_EWS: begin
					priority if (nntc_pkg::is_ws(ch_s1)) begin
						flt_n = flt_q;
					end else if (nntc_pkg::is_sign(ch_s1)) begin
						flt_n = nntc_pkg::FP_ESIGN;
					end else if (nntc_pkg::is_digit(ch_s1)) begin
						flt_n = nntc_pkg::FP_EDIG;
					end else begin
						flt_n = nntc_pkg::FP_FAIL;
						fv_n  = nntc_pkg::V_NO;
					end
				end
				nntc_pkg::FP_ESIGN: begin
					if (nntc_pkg::is_digit(ch_s1)) begin
						flt_n = nntc_pkg::FP_EDIG;
					end else begin
						flt_n = nntc_pkg::FP_FAIL;
						fv_n  = nntc_pkg::V_NO;
					end
				end
				nntc_pkg::FP_EDIG: begin
					if (!nntc_pkg::is_digit(ch_s1)) begin
						flt_n = nntc_pkg::FP_END;
						fv_n  = dv;
					end
				end
				default: ;
			endcase
		end
	end

	// name scanner, not stepped by the terminating NUL
	always_comb begin
		name_n = name_q;
		unique case (name_q)
			nntc_pkg::NP_UNDER: begin
				if (ch_s1 != nntc_pkg::ChUnder) begin
					name_n = nntc_pkg::is_letter(ch_s1) ? nntc_pkg::NP_BODY : nntc_pkg::NP_FAIL;
				end
			end
			nntc_pkg::NP_BODY: begin
				if (ch_s1 < nntc_pkg::ChGraphLo || ch_s1 > nntc_pkg::ChGraphHi) begin
					name_n = nntc_pkg::NP_FAIL;
				end
			end
			default: ;
		endcase
	end

	assign verdicts[0] = int_q == nntc_pkg::IP_DIG && int_n == nntc_pkg::IP_END;
	assign verdicts[1] = iv_n == nntc_pkg::V_YES;
	assign verdicts[2] = flt_q != nntc_pkg::FP_END && flt_n == nntc_pkg::FP_END;
	assign verdicts[3] = fv_n == nntc_pkg::V_YES;
	assign verdicts[4] = name_q == nntc_pkg::NP_BODY;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1 <= s_tdata;
		end
	end

	// scanner state, cleared after each terminating NUL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q   <= nntc_pkg::IP_WS;
			flt_q   <= nntc_pkg::FP_WS;
			name_q  <= nntc_pkg::NP_UNDER;
			iv_q    <= nntc_pkg::V_UNDEC;
			fv_q    <= nntc_pkg::V_UNDEC;
			mseen_q <= 1'b0;
		end else if (consume) begin
			if (is_nul) begin
				int_q   <= nntc_pkg::IP_WS;
				flt_q   <= nntc_pkg::FP_WS;
				name_q  <= nntc_pkg::NP_UNDER;
				iv_q    <= nntc_pkg::V_UNDEC;
				fv_q    <= nntc_pkg::V_UNDEC;
				mseen_q <= 1'b0;
			end else begin
				int_q   <= int_n;
				flt_q   <= flt_n;
				name_q  <= name_n;
				iv_q    <= iv_n;
				fv_q    <= fv_n;
				mseen_q <= mseen_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (consume && is_nul) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && is_nul) begin
			m_tdata <= {{(nntc_pkg::OutW - 5){1'b0}}, verdicts};
		end
	end

endmodule

`default_nettype wire
